>>> design/bbc_pkg.sv
package bbc_pkg;

    localparam int SLOT_COUNT_DEF = 32;
    localparam int DEV_W          = 8;
    localparam int BLK_W          = 20;
    localparam int CNT_W          = 8;
    localparam int IDX_W          = 5;

    typedef enum logic [1:0] {
        OP_GET     = 2'd0,
        OP_RELEASE = 2'd1,
        OP_PIN     = 2'd2,
        OP_UNPIN   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_MISS  = 2'd1,
        ST_NOBUF = 2'd2,
        ST_UNDER = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_GET_WB,
        S_UPD,
        S_MOVE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]       operation;
        logic [DEV_W-1:0] device_id;
        logic [BLK_W-1:0] block_number;
        logic [IDX_W-1:0] slot_index;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] slot_out;
        logic             need_fill;
        logic [CNT_W-1:0] ref_count_out;
    } rsp_t;

    typedef struct packed {
        logic [DEV_W-1:0] dev;
        logic [BLK_W-1:0] blk;
        logic             valid;
        logic [CNT_W-1:0] cnt;
    } tag_entry_t;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

endpackage

>>> design/block_buffer_cache_lru.sv
// Buffer cache tag/LRU engine, one request at a time.
// Get: the recency list is walked through a registered order RAM read feeding
// a tag RAM read, one position per cycle, early exit on hit.
// Release/pin/unpin: tag entry update, plus a move to the MRU end on a release to zero.
// After reset a clearing pass over all SLOT_COUNT entries initializes both RAMs; no
// request is taken until it ends.
module block_buffer_cache_lru #(
    parameter int SLOT_COUNT = bbc_pkg::SLOT_COUNT_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  bbc_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output bbc_pkg::rsp_t m_data
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int EW = $bits(bbc_pkg::tag_entry_t);
    localparam logic [SW-1:0] LAST = SW'(SLOT_COUNT - 1);

    bbc_pkg::state_t     state_reg, state_next;
    logic [SW-1:0]       pos_reg, pos_next;
    logic                active_reg, active_next;
    logic                v1_reg, v1_next;
    logic                last1_reg, last1_next;
    logic [SW-1:0]       pos1_reg, pos1_next;
    logic                v2_reg, v2_next;
    logic                last2_reg, last2_next;
    logic [SW-1:0]       slot2_reg, slot2_next;
    logic                hit_reg, hit_next;
    logic [SW-1:0]       sel_reg, sel_next;
    bbc_pkg::tag_entry_t ent_reg, ent_next;
    logic                free_reg, free_next;
    logic [SW-1:0]       free_slot_reg, free_slot_next;
    logic [SW-1:0]       carry_reg, carry_next;
    bbc_pkg::req_t       req_reg, req_next;
    bbc_pkg::rsp_t       res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    bbc_pkg::rsp_t       m_data_reg, m_data_next;

    logic                tag_we;
    logic [SW-1:0]       tag_waddr, tag_raddr;
    bbc_pkg::tag_entry_t tag_wdata, tag_rdata;
    logic [EW-1:0]       tag_rbits;
    logic                ord_we;
    logic [SW-1:0]       ord_waddr, ord_raddr, ord_wdata, ord_rdata;

    logic                idx_bad;
    logic [SW-1:0]       idx_addr;
    logic                tag_match;
    logic [bbc_pkg::CNT_W-1:0] cnt_inc, cnt_dec;

    assign tag_rdata = bbc_pkg::tag_entry_t'(tag_rbits);
    assign idx_bad   = 32'(s_data.slot_index) >= 32'(SLOT_COUNT);
    assign idx_addr  = SW'(s_data.slot_index);
    assign tag_match = (tag_rdata.dev == req_reg.device_id)
                    && (tag_rdata.blk == req_reg.block_number);
    assign cnt_inc   = (tag_rdata.cnt == bbc_pkg::CNT_MAX) ? tag_rdata.cnt
                                                           : tag_rdata.cnt + 1'b1;
    assign cnt_dec   = tag_rdata.cnt - 1'b1;

    bbc_ram #(.WIDTH(EW), .DEPTH(SLOT_COUNT)) u_tag_ram (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (EW'(tag_wdata)),
        .raddr (tag_raddr),
        .rdata (tag_rbits)
    );

    bbc_ram #(.WIDTH(SW), .DEPTH(SLOT_COUNT)) u_order_ram (
        .aclk  (aclk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    // next state and datapath
    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        active_next    = active_reg;
        v1_next        = 1'b0;
        last1_next     = 1'b0;
        pos1_next      = pos_reg;
        v2_next        = 1'b0;
        last2_next     = 1'b0;
        slot2_next     = ord_rdata;
        hit_next       = hit_reg;
        sel_next       = sel_reg;
        ent_next       = ent_reg;
        free_next      = free_reg;
        free_slot_next = free_slot_reg;
        carry_next     = carry_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        unique case (state_reg)
            bbc_pkg::S_CLEAR: begin
                pos_next = pos_reg + 1'b1;
                if (pos_reg == LAST) begin
                    pos_next   = '0;
                    state_next = bbc_pkg::S_IDLE;
                end
            end
            bbc_pkg::S_IDLE: begin
                if (s_valid) begin
                    req_next    = s_data;
                    pos_next    = '0;
                    active_next = 1'b1;
                    free_next   = 1'b0;
                    if (s_data.operation == bbc_pkg::OP_GET) begin
                        state_next = bbc_pkg::S_SCAN;
                    end else if (idx_bad) begin
                        res_next   = '{bbc_pkg::ST_NOBUF, s_data.slot_index, 1'b0, '0};
                        state_next = bbc_pkg::S_OUT;
                    end else begin
                        state_next = bbc_pkg::S_UPD;
                    end
                end
            end
            bbc_pkg::S_SCAN: begin
                if (active_reg) begin
                    if (pos_reg == LAST) active_next = 1'b0;
                    else pos_next = pos_reg + 1'b1;
                end
                v1_next    = active_reg;
                last1_next = pos_reg == LAST;
                v2_next    = v1_reg;
                last2_next = last1_reg;
                if (v2_reg) begin
                    if (tag_match) begin
                        hit_next   = 1'b1;
                        sel_next   = slot2_reg;
                        ent_next   = tag_rdata;
                        state_next = bbc_pkg::S_GET_WB;
                    end else begin
                        if (tag_rdata.cnt == '0) begin
                            free_next      = 1'b1;
                            free_slot_next = slot2_reg;
                        end
                        if (last2_reg) begin
                            hit_next   = 1'b0;
                            state_next = bbc_pkg::S_GET_WB;
                        end
                    end
                end
            end
            bbc_pkg::S_GET_WB: begin
                if (hit_reg) begin
                    res_next = '{bbc_pkg::ST_OK, bbc_pkg::IDX_W'(sel_reg), !ent_reg.valid,
                                 (ent_reg.cnt == bbc_pkg::CNT_MAX) ? ent_reg.cnt
                                                                   : ent_reg.cnt + 1'b1};
                end else if (free_reg) begin
                    res_next = '{bbc_pkg::ST_MISS, bbc_pkg::IDX_W'(free_slot_reg), 1'b1,
                                 bbc_pkg::CNT_W'(1)};
                end else begin
                    res_next = '{bbc_pkg::ST_NOBUF, '0, 1'b0, '0};
                end
                state_next = bbc_pkg::S_OUT;
            end
            bbc_pkg::S_UPD: begin
                state_next = bbc_pkg::S_OUT;
                if (req_reg.operation == bbc_pkg::OP_PIN) begin
                    res_next = '{bbc_pkg::ST_OK, req_reg.slot_index, 1'b0, cnt_inc};
                end else if (tag_rdata.cnt == '0) begin
                    res_next = '{bbc_pkg::ST_UNDER, req_reg.slot_index, 1'b0, '0};
                end else begin
                    res_next = '{bbc_pkg::ST_OK, req_reg.slot_index, 1'b0, cnt_dec};
                    if (req_reg.operation == bbc_pkg::OP_RELEASE && cnt_dec == '0) begin
                        carry_next = SW'(req_reg.slot_index);
                        state_next = bbc_pkg::S_MOVE;
                    end
                end
            end
            bbc_pkg::S_MOVE: begin
                // walk from MRU, shifting each entry down one until the slot is met
                pos_next  = pos_reg + 1'b1;
                v1_next   = 1'b1;
                pos1_next = pos_reg;
                if (v1_reg) begin
                    carry_next = ord_rdata;
                    if (ord_rdata == SW'(req_reg.slot_index)) begin
                        state_next = bbc_pkg::S_OUT;
                    end
                end
            end
            bbc_pkg::S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = bbc_pkg::S_IDLE;
                end
            end
            default: state_next = bbc_pkg::S_IDLE;
        endcase
    end

    // RAM control and handshake outputs
    always_comb begin
        tag_we    = 1'b0;
        tag_waddr = pos_reg;
        tag_wdata = '0;
        tag_raddr = '0;
        ord_we    = 1'b0;
        ord_waddr = pos1_reg;
        ord_wdata = carry_reg;
        ord_raddr = pos_reg;
        s_ready   = 1'b0;

        unique case (state_reg)
            bbc_pkg::S_CLEAR: begin
                tag_we    = 1'b1;
                ord_we    = 1'b1;
                ord_waddr = pos_reg;
                ord_wdata = LAST - pos_reg;
            end
            bbc_pkg::S_IDLE: begin
                s_ready   = 1'b1;
                tag_raddr = idx_addr;
            end
            bbc_pkg::S_SCAN: begin
                tag_raddr = ord_rdata;
            end
            bbc_pkg::S_GET_WB: begin
                if (hit_reg) begin
                    tag_we    = 1'b1;
                    tag_waddr = sel_reg;
                    tag_wdata = '{ent_reg.dev, ent_reg.blk, 1'b1,
                                  (ent_reg.cnt == bbc_pkg::CNT_MAX) ? ent_reg.cnt
                                                                    : ent_reg.cnt + 1'b1};
                end else if (free_reg) begin
                    tag_we    = 1'b1;
                    tag_waddr = free_slot_reg;
                    tag_wdata = '{req_reg.device_id, req_reg.block_number, 1'b1,
                                  bbc_pkg::CNT_W'(1)};
                end
            end
            bbc_pkg::S_UPD: begin
                tag_waddr = SW'(req_reg.slot_index);
                if (req_reg.operation == bbc_pkg::OP_PIN) begin
                    tag_we    = 1'b1;
                    tag_wdata = '{tag_rdata.dev, tag_rdata.blk, tag_rdata.valid, cnt_inc};
                end else if (tag_rdata.cnt != '0) begin
                    tag_we    = 1'b1;
                    tag_wdata = '{tag_rdata.dev, tag_rdata.blk, tag_rdata.valid, cnt_dec};
                end
            end
            bbc_pkg::S_MOVE: begin
                ord_we = v1_reg;
            end
            bbc_pkg::S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bbc_pkg::S_CLEAR;
            pos_reg     <= '0;
            active_reg  <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            last1_reg   <= 1'b0;
            last2_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            active_reg  <= active_next;
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            last1_reg   <= last1_next;
            last2_reg   <= last2_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos1_reg      <= pos1_next;
        slot2_reg     <= slot2_next;
        hit_reg       <= hit_next;
        sel_reg       <= sel_next;
        ent_reg       <= ent_next;
        free_reg      <= free_next;
        free_slot_reg <= free_slot_next;
        carry_reg     <= carry_next;
        req_reg       <= req_next;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
    end

`ifndef SYNTHESIS
    a_out_from_out_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == bbc_pkg::S_OUT))
        else $error("result raised outside output state");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bbc_pkg::S_IDLE) |-> (!tag_we && !ord_we))
        else $error("RAM write while idle");

    a_miss_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status == bbc_pkg::ST_MISS)
            |-> (m_data_reg.need_fill && m_data_reg.ref_count_out == bbc_pkg::CNT_W'(1)))
        else $error("miss result without fill or unit count");
`endif

endmodule

>>> design/bbc_ram.sv
module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> dv/testbench.sv
module testbench;

    localparam int SLOTS = bbc_pkg::SLOT_COUNT_DEF;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    bbc_pkg::req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    bbc_pkg::rsp_t m_data;

    block_buffer_cache_lru DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // cache image kept alongside the block
    logic [bbc_pkg::DEV_W-1:0] cache_dev [SLOTS];
    logic [bbc_pkg::BLK_W-1:0] cache_blk [SLOTS];
    logic                      cache_vld [SLOTS];
    logic [bbc_pkg::CNT_W-1:0] cache_cnt [SLOTS];
    logic [bbc_pkg::IDX_W-1:0] lru_list  [SLOTS];  // index 0 is MRU

    bbc_pkg::rsp_t pending_rsp[$];
    int   mismatches = 0;
    int   sink_hold = 0;      // long receiver hold-off, in cycles
    bit   quiet = 1'b0;       // no idling in the last part
    bit   tb_done = 1'b0;

    // device/block tags in play, kept small so hits are common
    logic [bbc_pkg::DEV_W-1:0] tag_dev_pool [8];
    logic [bbc_pkg::BLK_W-1:0] tag_blk_pool [8];

    function automatic bbc_pkg::rsp_t cache_step(bbc_pkg::req_t rq);
        bbc_pkg::rsp_t r;
        int   s, p;
        r = '0;
        if (bbc_pkg::op_t'(rq.operation) == bbc_pkg::OP_GET) begin
            for (int i = 0; i < SLOTS; i++) begin
                s = int'(lru_list[i]);
                if (cache_dev[s] == rq.device_id && cache_blk[s] == rq.block_number) begin
                    if (cache_cnt[s] != bbc_pkg::CNT_MAX) cache_cnt[s]++;
                    r.status = bbc_pkg::ST_OK;
                    r.slot_out = bbc_pkg::IDX_W'(s);
                    r.need_fill = !cache_vld[s];
                    r.ref_count_out = cache_cnt[s];
                    cache_vld[s] = 1'b1;
                    return r;
                end
            end
            for (int i = SLOTS - 1; i >= 0; i--) begin
                s = int'(lru_list[i]);
                if (cache_cnt[s] == 0) begin
                    cache_dev[s] = rq.device_id;
                    cache_blk[s] = rq.block_number;
                    cache_cnt[s] = bbc_pkg::CNT_W'(1);
                    cache_vld[s] = 1'b1;
                    r.status = bbc_pkg::ST_MISS;
                    r.slot_out = bbc_pkg::IDX_W'(s);
                    r.need_fill = 1'b1;
                    r.ref_count_out = bbc_pkg::CNT_W'(1);
                    return r;
                end
            end
            r.status = bbc_pkg::ST_NOBUF;
            return r;
        end
        s = int'(rq.slot_index);
        r.slot_out = rq.slot_index;
        if (s >= SLOTS) begin
            r.status = bbc_pkg::ST_NOBUF;
            return r;
        end
        if (bbc_pkg::op_t'(rq.operation) == bbc_pkg::OP_PIN) begin
            if (cache_cnt[s] != bbc_pkg::CNT_MAX) cache_cnt[s]++;
            r.status = bbc_pkg::ST_OK;
            r.ref_count_out = cache_cnt[s];
            return r;
        end
        if (cache_cnt[s] == 0) begin
            r.status = bbc_pkg::ST_UNDER;
            return r;
        end
        cache_cnt[s]--;
        if (bbc_pkg::op_t'(rq.operation) == bbc_pkg::OP_RELEASE && cache_cnt[s] == 0) begin
            p = 0;
            while (int'(lru_list[p]) != s) p++;
            for (int i = p; i > 0; i--) lru_list[i] = lru_list[i-1];
            lru_list[0] = bbc_pkg::IDX_W'(s);
        end
        r.status = bbc_pkg::ST_OK;
        r.ref_count_out = cache_cnt[s];
        return r;
    endfunction

    task automatic send_request(bbc_pkg::req_t rq);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data <= rq;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_rsp.push_back(cache_step(rq));
        @(negedge aclk);
    endtask

    function automatic bbc_pkg::req_t make_req(bbc_pkg::op_t op,
                                               logic [bbc_pkg::DEV_W-1:0] dev,
                                               logic [bbc_pkg::BLK_W-1:0] blk,
                                               logic [bbc_pkg::IDX_W-1:0] idx);
        bbc_pkg::req_t rq;
        rq.operation = op;
        rq.device_id = dev;
        rq.block_number = blk;
        rq.slot_index = idx;
        return rq;
    endfunction

    function automatic bbc_pkg::req_t random_req();
        int k;
        logic [63:0] raw;
        k = $urandom_range(0, 99);
        raw = {$urandom, $urandom};
        if (k < 5)
            return bbc_pkg::req_t'(raw[$bits(bbc_pkg::req_t)-1:0]);
        if (k < 45)
            return make_req(bbc_pkg::OP_GET, tag_dev_pool[$urandom_range(0, 7)],
                            tag_blk_pool[$urandom_range(0, 7)],
                            bbc_pkg::IDX_W'($urandom));
        if (k < 80)
            return make_req(bbc_pkg::OP_RELEASE, bbc_pkg::DEV_W'($urandom),
                            bbc_pkg::BLK_W'($urandom),
                            bbc_pkg::IDX_W'($urandom_range(0, SLOTS - 1)));
        if (k < 90)
            return make_req(bbc_pkg::OP_PIN, bbc_pkg::DEV_W'($urandom),
                            bbc_pkg::BLK_W'($urandom),
                            bbc_pkg::IDX_W'($urandom_range(0, SLOTS - 1)));
        return make_req(bbc_pkg::OP_UNPIN, bbc_pkg::DEV_W'($urandom),
                        bbc_pkg::BLK_W'($urandom),
                        bbc_pkg::IDX_W'($urandom_range(0, SLOTS - 1)));
    endfunction

    // result sink: random stalls, plus a long hold-off on request
    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            if (sink_hold > 0) begin
                m_ready <= 1'b0;
                sink_hold--;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                gap = $urandom_range(1, 5);
                repeat (gap - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        bbc_pkg::rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_data);
            end else begin
                want = pending_rsp.pop_front();
                if (m_data.status !== want.status || m_data.slot_out !== want.slot_out ||
                    m_data.need_fill !== want.need_fill ||
                    m_data.ref_count_out !== want.ref_count_out) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected st=%0d slot=%0d fill=%0d cnt=%0d,",
                                  " got st=%0d slot=%0d fill=%0d cnt=%0d"},
                                 want.status, want.slot_out, want.need_fill,
                                 want.ref_count_out,
                                 m_data.status, m_data.slot_out, m_data.need_fill,
                                 m_data.ref_count_out);
                end
            end
        end
    end

    task automatic test_directed();
        send_request(make_req(bbc_pkg::OP_GET, 8'h00, 20'h00000, 5'd0));   // matches reset tag, not valid
        send_request(make_req(bbc_pkg::OP_GET, 8'h00, 20'h00000, 5'd31));  // now valid hit
        send_request(make_req(bbc_pkg::OP_GET, 8'hFF, 20'hFFFFF, 5'd0));   // miss
        send_request(make_req(bbc_pkg::OP_GET, 8'hA5, 20'h5A5A5, 5'd17));
        send_request(make_req(bbc_pkg::OP_UNPIN, 8'h00, 20'h0, 5'd5));     // underflow
        send_request(make_req(bbc_pkg::OP_RELEASE, 8'h00, 20'h0, 5'd5));   // underflow
        send_request(make_req(bbc_pkg::OP_PIN, 8'hFF, 20'hFFFFF, 5'd31));
        send_request(make_req(bbc_pkg::OP_UNPIN, 8'h00, 20'h0, 5'd31));
        send_request(make_req(bbc_pkg::OP_RELEASE, 8'h00, 20'h0, 5'd1));
        // pin slot 2 past the top of its count
        repeat (257) send_request(make_req(bbc_pkg::OP_PIN, 8'h00, 20'h0, 5'd2));
        repeat (3) send_request(make_req(bbc_pkg::OP_UNPIN, 8'h00, 20'h0, 5'd2));
        repeat (253) send_request(make_req(bbc_pkg::OP_RELEASE, 8'h00, 20'h0, 5'd2));
    endtask

    task automatic test_cache_full();
        for (int i = 0; i < SLOTS + 2; i++)
            send_request(make_req(bbc_pkg::OP_GET, 8'h3C, 20'(i + 100), 5'd0));
        send_request(make_req(bbc_pkg::OP_GET, 8'h3C, 20'd99, 5'd0));      // no free buffer
        for (int i = 0; i < SLOTS; i++)
            send_request(make_req(bbc_pkg::OP_RELEASE, 8'h0, 20'h0, 5'(i)));
    endtask

    task automatic test_backpressure();
        sink_hold = 60;
        for (int i = 0; i < 10; i++) send_request(random_req());
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            if (i == n - 150) quiet = 1'b1;
            send_request(random_req());
        end
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            cache_dev[i] = '0;
            cache_blk[i] = '0;
            cache_vld[i] = 1'b0;
            cache_cnt[i] = '0;
            lru_list[i] = bbc_pkg::IDX_W'(SLOTS - 1 - i);
        end
        for (int i = 0; i < 8; i++) begin
            tag_dev_pool[i] = bbc_pkg::DEV_W'($urandom);
            tag_blk_pool[i] = bbc_pkg::BLK_W'($urandom);
        end
        tag_dev_pool[0] = 8'hFF;
        tag_blk_pool[0] = 20'hFFFFF;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_cache_full();
        test_backpressure();
        test_random(450);
        s_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        tb_done = 1'b1;
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #2000000;
        if (!tb_done) begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule

>>> filelist.f
design/bbc_pkg.sv
design/bbc_ram.sv
design/block_buffer_cache_lru.sv
dv/testbench.sv
